>>> rtl/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants, types and byte-level helpers for the subword piece
// detokenizer: marker bytes, match progress codes and the space-rule step.
// ----------------------------------------------------------------------------
package spd_pkg;

  // Piece head length held before the piece's length is known
  localparam int HeadLen = 6;
  // Result register room in text bytes; one input byte releases at most six
  localparam int NumOut  = 7;
  // Count widths
  localparam int HeadCntW = $clog2(HeadLen + 1);
  localparam int OutCntW  = $clog2(NumOut + 1);

  // Space marker E2 96 81 and the byte it becomes
  localparam logic [7:0] Mark0     = 8'hE2;
  localparam logic [7:0] Mark1     = 8'h96;
  localparam logic [7:0] Mark2     = 8'h81;
  localparam logic [7:0] SpaceByte = 8'h20;

  // Byte-fallback frame characters
  localparam logic [7:0] ChLt   = 8'h3C;  // '<'
  localparam logic [7:0] ChZero = 8'h30;  // '0'
  localparam logic [7:0] ChX    = 8'h78;  // 'x'
  localparam logic [7:0] ChGt   = 8'h3E;  // '>'

  // Partial space match progress
  localparam logic [1:0] MatchNone  = 2'd0;
  localparam logic [1:0] MatchE2    = 2'd1;
  localparam logic [1:0] MatchE2_96 = 2'd2;

  // Outcome of feeding one byte through the space rule
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      n;
    logic [1:0]      mp;
  } feed_t;

  // Outcome of feeding a run of bytes, plus optional flush
  typedef struct packed {
    logic [NumOut-1:0][7:0] data;
    logic [OutCntW-1:0]     n;
    logic [1:0]             mp;
  } run_t;

  // Hex digit decode of either case
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.val = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.val = 4'(c - 8'h61 + 8'd10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // One step of the space rule
  function automatic feed_t feed_byte(input logic [1:0] mp, input logic [7:0] b);
    feed_t r;
    logic  pass;
    r.data = '0;
    r.n    = 2'd0;
    r.mp   = MatchNone;
    pass   = 1'b1;
    case (mp)
      MatchE2: begin
        if (b == Mark1) begin
          r.mp = MatchE2_96;
          pass = 1'b0;
        end else begin
          r.data[0] = Mark0;
          r.n       = 2'd1;
        end
      end
      MatchE2_96: begin
        if (b == Mark2) begin
          r.data[0] = SpaceByte;
          r.n       = 2'd1;
          pass      = 1'b0;
        end else begin
          // broken match: held bytes go out, this byte is examined again
          r.data[0] = Mark0;
          r.data[1] = Mark1;
          r.n       = 2'd2;
        end
      end
      default: begin
      end
    endcase
    if (pass) begin
      if (b == Mark0) begin
        r.mp = MatchE2;
      end else begin
        r.data[r.n] = b;
        r.n         = r.n + 2'd1;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/subword_piece_detokenizer.sv
// ----------------------------------------------------------------------------
// subword_piece_detokenizer
// Streaming detokenizer: piece bytes in, text bytes out, with byte fallback
// for <0xHH> pieces and E2 96 81 turned into a space.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one piece byte per
//   transaction, with piece_end_i on the final byte of each piece.
//   Output channel (out_valid_o/out_ready_i) carries one text byte per
//   transaction; run_last_o marks the last byte released by an input byte,
//   piece_done_o the last byte of a piece.
//   Each accepted byte is decoded in the same cycle into 0 to 6 text bytes,
//   which land in a result shift register; the first is offered on the next
//   cycle. The register drains one byte per cycle while out_ready_i is high.
//   Throughput: one input byte per cycle while each releases at most one
//   text byte and the receiver does not stall; an input releasing k bytes
//   holds the output until all k are taken, and the next input is taken in
//   the cycle its last byte is taken. Inputs that release nothing pass at one per cycle.
//   Reset clears the piece state and empties the result register.
//   When the receiver stalls, the result register holds and in_ready_o
//   drops once the pending bytes cannot all leave in this cycle.
// ----------------------------------------------------------------------------
module subword_piece_detokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] piece_byte_i,
  input  logic       piece_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] text_byte_o,
  output logic       run_last_o,
  output logic       piece_done_o
);

  localparam int HeadLen  = spd_pkg::HeadLen;
  localparam int NumOut   = spd_pkg::NumOut;
  localparam int HeadCntW = spd_pkg::HeadCntW;
  localparam int OutCntW  = spd_pkg::OutCntW;

  // Feed a run of bytes through the space rule, optionally flushing
  function automatic spd_pkg::run_t run_bytes(
    input logic [1:0]                mp0,
    input logic [HeadLen-1:0][7:0]   src,
    input logic [HeadCntW-1:0]       nsrc,
    input logic                      flush
  );
    spd_pkg::run_t  r;
    spd_pkg::feed_t f;
    logic [1:0]     mp;
    r.data = '0;
    r.n    = '0;
    mp     = mp0;
    for (int i = 0; i < HeadLen; i++) begin
      if (HeadCntW'(i) < nsrc) begin
        f  = spd_pkg::feed_byte(mp, src[i]);
        mp = f.mp;
        for (int j = 0; j < 3; j++) begin
          if (2'(j) < f.n && r.n < OutCntW'(NumOut)) begin
            r.data[r.n] = f.data[j];
            r.n         = r.n + 1'b1;
          end
        end
      end
    end
    if (flush) begin
      if ((mp == spd_pkg::MatchE2 || mp == spd_pkg::MatchE2_96) &&
          r.n < OutCntW'(NumOut)) begin
        r.data[r.n] = spd_pkg::Mark0;
        r.n         = r.n + 1'b1;
      end
      if (mp == spd_pkg::MatchE2_96 && r.n < OutCntW'(NumOut)) begin
        r.data[r.n] = spd_pkg::Mark1;
        r.n         = r.n + 1'b1;
      end
      mp = spd_pkg::MatchNone;
    end
    r.mp = mp;
    return r;
  endfunction

  // Piece state
  logic [HeadLen-1:0][7:0] head_q;
  logic [HeadCntW-1:0]     cnt_q, cnt_d;
  logic                    past_q, past_d;
  logic [1:0]              mp_q, mp_d;

  // Result shift register
  logic [NumOut-1:0][7:0]  buf_q, buf_d;
  logic [OutCntW-1:0]      left_q, left_d;
  logic                    end_q, end_d;

  logic                    in_acc, out_acc;
  logic [HeadLen-1:0][7:0] head_n;
  logic [HeadCntW-1:0]     cnt_n;
  logic                    head_full;
  spd_pkg::hex_t           hex_hi, hex_lo;
  logic                    fb_ok;
  logic [1:0]              eng_mp0;
  logic [HeadLen-1:0][7:0] eng_src;
  logic [HeadCntW-1:0]     eng_n;
  spd_pkg::run_t           eng;
  logic [NumOut-1:0][7:0]  res_data;
  logic [OutCntW-1:0]      res_n;

  // Handshakes
  assign out_valid_o  = (left_q != '0);
  assign in_ready_o   = (left_q == '0) || (left_q == OutCntW'(1) && out_ready_i);
  assign in_acc       = in_valid_i && in_ready_o;
  assign out_acc      = out_valid_o && out_ready_i;
  assign text_byte_o  = buf_q[0];
  assign run_last_o   = (left_q == OutCntW'(1));
  assign piece_done_o = run_last_o && end_q;

  // Head with the incoming byte placed
  always_comb begin
    for (int i = 0; i < HeadLen; i++) begin
      head_n[i] = (HeadCntW'(i) == cnt_q) ? piece_byte_i : head_q[i];
    end
  end
  assign cnt_n     = cnt_q + 1'b1;
  assign head_full = (cnt_n == HeadCntW'(HeadLen));

  // Byte-fallback check on a complete six-byte head
  assign hex_hi = spd_pkg::hex_digit(head_n[3]);
  assign hex_lo = spd_pkg::hex_digit(head_n[4]);
  assign fb_ok  = head_full && head_n[0] == spd_pkg::ChLt && head_n[1] == spd_pkg::ChZero &&
                  head_n[2] == spd_pkg::ChX && head_n[5] == spd_pkg::ChGt &&
                  hex_hi.ok && hex_lo.ok;

  // Space-rule engine: single byte past the head, or the whole head
  always_comb begin
    if (past_q) begin
      eng_mp0    = mp_q;
      eng_src    = head_n;
      eng_src[0] = piece_byte_i;
      eng_n      = HeadCntW'(1);
    end else begin
      eng_mp0 = spd_pkg::MatchNone;
      eng_src = head_n;
      eng_n   = cnt_n;
    end
  end
  assign eng = run_bytes(eng_mp0, eng_src, eng_n, piece_end_i);

  // Results and next piece state for the incoming byte
  always_comb begin
    res_data = eng.data;
    res_n    = eng.n;
    cnt_d    = cnt_q;
    past_d   = past_q;
    mp_d     = mp_q;
    if (!past_q) begin
      cnt_d = cnt_n;
      if (piece_end_i && fb_ok) begin
        res_data    = '0;
        res_data[0] = {hex_hi.val, hex_lo.val};
        res_n       = OutCntW'(1);
      end else if (!piece_end_i && !head_full) begin
        res_n = '0;
      end else if (!piece_end_i) begin
        past_d = 1'b1;
        mp_d   = eng.mp;
      end
    end else begin
      mp_d = eng.mp;
    end
    if (piece_end_i) begin
      cnt_d  = '0;
      past_d = 1'b0;
      mp_d   = spd_pkg::MatchNone;
    end
  end

  // Result register load and drain
  always_comb begin
    buf_d  = buf_q;
    left_d = left_q;
    end_d  = end_q;
    if (in_acc) begin
      buf_d  = res_data;
      left_d = res_n;
      end_d  = piece_end_i;
    end else if (out_acc) begin
      for (int i = 0; i < NumOut - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      left_d = left_q - 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      past_q <= 1'b0;
      mp_q   <= spd_pkg::MatchNone;
      left_q <= '0;
      end_q  <= 1'b0;
    end else begin
      left_q <= left_d;
      end_q  <= end_d;
      if (in_acc) begin
        cnt_q  <= cnt_d;
        past_q <= past_d;
        mp_q   <= mp_d;
      end
    end
  end

  // Payload storage
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (in_acc && !past_q) begin
      head_q <= head_n;
    end
  end

endmodule

>>> sim/subword_piece_detokenizer_test.sv
// ----------------------------------------------------------------------------
// subword_piece_detokenizer_test
// Self-checking bench for the subword piece detokenizer. A directed set of
// pieces (byte fallback, bad hex, space marker, split markers, long pieces)
// is followed by randomly built pieces, with random idle gaps on the input
// side and random stalls on the output side. A scoreboard predicts each
// text byte transaction and checks it field by field.
// ----------------------------------------------------------------------------
class detok_scoreboard;

  typedef struct packed {
    logic [7:0] text;
    logic       last;
    logic       done;
  } text_item_t;

  // predictor state
  logic [7:0] head_q [spd_pkg::HeadLen];
  int         head_cnt;
  bit         beyond_head;
  logic [1:0] partial;

  logic [7:0]  burst [$];
  text_item_t  text_due [$];
  int unsigned errors;

  function new();
    head_cnt    = 0;
    beyond_head = 1'b0;
    partial     = spd_pkg::MatchNone;
    errors      = 0;
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // append one predicted text byte to the current burst
  function void emit_byte(logic [7:0] b);
    burst = {burst, b};
  endfunction

  // hex digit of either case, -1 when not a digit
  function int nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return int'(c) - 'h30;
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      return int'(c) - 'h41 + 10;
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      return int'(c) - 'h61 + 10;
    end
    return -1;
  endfunction

  // space rule, one byte
  function void space_rule(logic [7:0] b);
    if (partial == spd_pkg::MatchE2) begin
      if (b == spd_pkg::Mark1) begin
        partial = spd_pkg::MatchE2_96;
        return;
      end
      emit_byte(spd_pkg::Mark0);
      partial = spd_pkg::MatchNone;
    end else if (partial == spd_pkg::MatchE2_96) begin
      if (b == spd_pkg::Mark2) begin
        emit_byte(spd_pkg::SpaceByte);
        partial = spd_pkg::MatchNone;
        return;
      end
      emit_byte(spd_pkg::Mark0);
      emit_byte(spd_pkg::Mark1);
      partial = spd_pkg::MatchNone;
    end
    // broken or no match: this byte may start a new one
    if (b == spd_pkg::Mark0) begin
      partial = spd_pkg::MatchE2;
    end else begin
      emit_byte(b);
    end
  endfunction

  function void release_partial();
    if (partial != spd_pkg::MatchNone) begin
      emit_byte(spd_pkg::Mark0);
    end
    if (partial == spd_pkg::MatchE2_96) begin
      emit_byte(spd_pkg::Mark1);
    end
    partial = spd_pkg::MatchNone;
  endfunction

  function void release_head();
    partial = spd_pkg::MatchNone;
    for (int i = 0; i < head_cnt; i++) begin
      space_rule(head_q[i]);
    end
  endfunction

  // accepted input transaction: predict the text bytes it releases
  function void take_piece_byte(logic [7:0] b, logic e);
    int         hi;
    int         lo;
    bit         fallback;
    text_item_t item;
    burst.delete();
    if (!beyond_head) begin
      if (head_cnt < spd_pkg::HeadLen) begin
        head_q[head_cnt] = b;
        head_cnt++;
      end
      if (e) begin
        fallback = 1'b0;
        if (head_cnt == spd_pkg::HeadLen && head_q[0] == spd_pkg::ChLt &&
            head_q[1] == spd_pkg::ChZero && head_q[2] == spd_pkg::ChX &&
            head_q[5] == spd_pkg::ChGt) begin
          hi = nibble_of(head_q[3]);
          lo = nibble_of(head_q[4]);
          if (hi >= 0 && lo >= 0) begin
            emit_byte(8'((hi << 4) | lo));
            fallback = 1'b1;
          end
        end
        if (!fallback) begin
          release_head();
          release_partial();
        end
      end else if (head_cnt == spd_pkg::HeadLen) begin
        // piece longer than the head: release it, keep a partial match
        release_head();
        beyond_head = 1'b1;
      end
    end else begin
      space_rule(b);
      if (e) begin
        release_partial();
      end
    end
    if (e) begin
      head_cnt    = 0;
      beyond_head = 1'b0;
      partial     = spd_pkg::MatchNone;
    end
    foreach (burst[k]) begin
      item.text = burst[k];
      item.last = (k == burst.size() - 1);
      item.done = item.last && e;
      text_due  = {text_due, item};
    end
  endfunction

  // accepted output transaction
  function void check_text_byte(logic [7:0] t, logic l, logic d);
    text_item_t want;
    if (text_due.size() == 0) begin
      flag($sformatf("unexpected text byte %02h last=%0b done=%0b", t, l, d));
      return;
    end
    want = text_due.pop_front();
    if (t !== want.text || l !== want.last || d !== want.done) begin
      flag($sformatf({"mismatch: expected byte %02h last=%0b done=%0b, ",
                      "got %02h last=%0b done=%0b"},
                     want.text, want.last, want.done, t, l, d));
    end
  endfunction

endclass

module subword_piece_detokenizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 250000;
  localparam int RandItems  = 125;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic [7:0] piece_byte_i = 8'h00;
  logic       piece_end_i  = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic [7:0] text_byte_o;
  logic       run_last_o;
  logic       piece_done_o;

  detok_scoreboard sb = new();
  int unsigned     cycle_cnt = 0;
  int unsigned     items_sent = 0;
  logic [7:0]      piece_q [$];

  subword_piece_detokenizer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .piece_byte_i(piece_byte_i),
    .piece_end_i (piece_end_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .text_byte_o (text_byte_o),
    .run_last_o  (run_last_o),
    .piece_done_o(piece_done_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("subword_piece_detokenizer_test: done, errors");
      $finish;
    end
  end

  // monitor: results checked before the same edge's input is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_text_byte(text_byte_o, run_last_o, piece_done_o);
      end
      if (in_valid_i && in_ready_o) begin
        sb.take_piece_byte(piece_byte_i, piece_end_i);
      end
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v, bit upper);
    if (v < 10) begin
      return 8'h30 + 8'(v);
    end
    return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  // append one byte to the piece being built
  function automatic void add_piece_byte(logic [7:0] b);
    piece_q = {piece_q, b};
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic e, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    piece_byte_i <= b;
    piece_end_i  <= e;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_piece(input logic [7:0] bytes [$]);
    bit no_gap;
    no_gap = ($urandom_range(0, 3) == 0);
    foreach (bytes[i]) begin
      send_byte(bytes[i], i == bytes.size() - 1, no_gap);
    end
  endtask

  // well-formed <0xHH> piece with random digits and case
  task automatic make_fallback();
    piece_q = {spd_pkg::ChLt, spd_pkg::ChZero, spd_pkg::ChX,
               hex_char(4'($urandom), 1'($urandom_range(0, 1))),
               hex_char(4'($urandom), 1'($urandom_range(0, 1))), spd_pkg::ChGt};
  endtask

  // text piece rich in space markers, whole and partial
  task automatic make_text(input int unsigned len);
    int unsigned r;
    piece_q.delete();
    while (piece_q.size() < len) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        add_piece_byte(spd_pkg::Mark0);
        add_piece_byte(spd_pkg::Mark1);
        add_piece_byte(spd_pkg::Mark2);
      end else if (r < 5) begin
        add_piece_byte(spd_pkg::Mark0);
        if (r == 4) begin
          add_piece_byte(spd_pkg::Mark1);
        end
      end else if (r == 5) begin
        case ($urandom_range(0, 2))
          0: add_piece_byte(spd_pkg::Mark0);
          1: add_piece_byte(spd_pkg::Mark1);
          default: add_piece_byte(spd_pkg::Mark2);
        endcase
      end else begin
        add_piece_byte(8'($urandom));
      end
    end
  endtask

  // random receiver stalls, with stall-free stretches
  initial begin
    @(posedge clk_i iff rst_ni);
    forever begin
      int unsigned stall;
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      stall = pick_gap();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned kind;
    int unsigned target;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte fallback, lowercase digit
    piece_q = {spd_pkg::ChLt, spd_pkg::ChZero, spd_pkg::ChX, 8'h34, 8'h61, spd_pkg::ChGt};
    send_piece(piece_q);
    // bad hex digit: copied as text
    piece_q = {spd_pkg::ChLt, spd_pkg::ChZero, spd_pkg::ChX, 8'h34, 8'h67, spd_pkg::ChGt};
    send_piece(piece_q);
    // whole space marker
    piece_q = {spd_pkg::Mark0, spd_pkg::Mark1, spd_pkg::Mark2};
    send_piece(piece_q);
    // marker split across the end of the head
    piece_q = {8'h61, 8'h62, 8'h63, 8'h64, spd_pkg::Mark0, spd_pkg::Mark1, spd_pkg::Mark2};
    send_piece(piece_q);
    // extremes of the byte field, single-byte pieces
    piece_q = {8'h00};
    send_piece(piece_q);
    piece_q = {8'hFF};
    send_piece(piece_q);
    // broken match restarts on the breaking byte, then flushed at end
    piece_q = {spd_pkg::Mark0, spd_pkg::Mark0};
    send_piece(piece_q);

    // random pieces
    target = items_sent + RandItems;
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        make_fallback();
      end else if (kind < 42) begin
        make_fallback();
        piece_q[$urandom_range(0, 5)] = 8'($urandom);
      end else if (kind < 52) begin
        make_fallback();
        if ($urandom_range(0, 1) == 0) begin
          void'(piece_q.pop_back());
        end else begin
          add_piece_byte(8'($urandom));
        end
      end else if (kind < 90) begin
        make_text($urandom_range(1, 12));
      end else begin
        piece_q.delete();
        repeat ($urandom_range(1, 4)) add_piece_byte(8'($urandom));
      end
      send_piece(piece_q);
    end
    in_valid_i <= 1'b0;

    // let the last input be noted, drain, then allow stray results to show up
    @(posedge clk_i);
    while (sb.text_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("subword_piece_detokenizer_test: done, clean");
    end else begin
      $display("subword_piece_detokenizer_test: done, errors");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/spd_pkg.sv
rtl/subword_piece_detokenizer.sv
sim/subword_piece_detokenizer_test.sv
